>>> src/tspid_pkg.sv
// shared widths for the timestamped pid controller
`default_nettype none
package tspid_pkg;
   localparam int MUL_A_W = 48;
   localparam int MUL_B_W = 32;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int DIV_N_W = 72;
   localparam int DIV_D_W = 32;
   typedef logic [MUL_P_W-1:0] mul_prod_type;
   typedef logic [DIV_N_W-1:0] div_quo_type;
endpackage
`default_nettype wire

>>> src/tspid_mul.sv
// bit-serial unsigned multiplier, one multiplier bit per cycle
`default_nettype none
module tspid_mul (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [tspid_pkg::MUL_A_W-1:0] a,
   input  wire logic [tspid_pkg::MUL_B_W-1:0] b,
   output logic                               done,
   output tspid_pkg::mul_prod_type            prod
);
   import tspid_pkg::*;
   localparam int CNT_W = $clog2(MUL_B_W + 1);

   logic                busy_ff, busy_in, done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [MUL_A_W-1:0]  a_ff, a_in;
   mul_prod_type        p_ff, p_in;
   logic [MUL_A_W:0]    sum;

   always_comb begin
      sum = {1'b0, p_ff[MUL_P_W-1:MUL_B_W]} + (p_ff[0] ? {1'b0, a_ff} : '0);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      a_in = a_ff;
      p_in = p_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = CNT_W'(MUL_B_W);
         a_in = a;
         p_in = {{MUL_A_W{1'b0}}, b};
      end else if (busy_ff) begin
         p_in = {sum, p_ff[MUL_B_W-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      a_ff <= a_in;
      p_ff <= p_in;
   end

   assign done = done_ff;
   assign prod = p_ff;
endmodule
`default_nettype wire

>>> src/tspid_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module tspid_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [tspid_pkg::DIV_N_W-1:0] dividend,
   input  wire logic [tspid_pkg::DIV_D_W-1:0] divisor,
   output logic                               done,
   output tspid_pkg::div_quo_type             quo
);
   import tspid_pkg::*;
   localparam int CNT_W = $clog2(DIV_N_W + 1);

   logic               busy_ff, busy_in, done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DIV_D_W-1:0] rem_ff, rem_in, dv_ff, dv_in;
   div_quo_type        q_ff, q_in;
   logic [DIV_D_W:0]   t, tdiff;
   logic               ge;

   always_comb begin
      t = {rem_ff, q_ff[DIV_N_W-1]};
      tdiff = t - {1'b0, dv_ff};
      ge = (t >= {1'b0, dv_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      dv_in = dv_ff;
      q_in = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = CNT_W'(DIV_N_W);
         rem_in = '0;
         dv_in = divisor;
         q_in = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? tdiff[DIV_D_W-1:0] : t[DIV_D_W-1:0];
         q_in = {q_ff[DIV_N_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      dv_ff <= dv_in;
      q_ff <= q_in;
   end

   assign done = done_ff;
   assign quo = q_ff;
endmodule
`default_nettype wire

>>> src/timestamped_pid_controller_top.sv
// Timestamped positional PID controller, signed Q16.16 throughout.
// req channel: one item per update, tuser = func (1 resets integral and history),
// tdata = error sample and microsecond timestamp. rsp channel: one item per
// request, tdata = control value, tuser = status (1 when the timestamp is not
// after the previous one). The user must write gains and limits over the csr
// port only while no item is in flight; the block does not enforce this.
// A reset request goes straight to the rsp output register. A full update forms
// the proportional product, the integral increment (product, then quotient),
// the integral term (product) and the derivative (product, then quotient), then
// sums and registers; the integral increment is skipped without ki and the
// derivative without kd. The first update after reset and a time error stop
// after the proportional product. Products run on the bit-serial multiplier,
// shared by all terms; quotients on the bit-serial divider, for the I and D terms.
// One item is worked on at a time; req_tready is high only when idle, so the
// next item is accepted once the previous result is in the rsp output register.
// Reset zeroes the integral, history and csr registers and empties the rsp register.
// A result waits in the rsp output register until taken; a stalled receiver
// holds the block after its current item.
`default_nettype none
module timestamped_pid_controller_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,  // error_value[31:0], stamp_us[63:32]
   input  wire logic [0:0]  req_tuser,  // func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,  // control_out[31:0]
   output logic [0:0]       rsp_tuser,  // status
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import tspid_pkg::*;

   localparam logic [2:0] R_GP = 3'd0, R_GI = 3'd1, R_GD = 3'd2, R_OLO = 3'd3,
                          R_OHI = 3'd4, R_ILO = 3'd5, R_IHI = 3'd6, R_EN = 3'd7;
   localparam logic [3:0] S_IDLE = 4'd0, S_P = 4'd1, S_IM = 4'd2, S_ID = 4'd3,
                          S_ITS = 4'd4, S_IT = 4'd5, S_DM = 4'd6, S_DD = 4'd7,
                          S_SUM = 4'd8, S_OUT = 4'd9;
   localparam logic signed [49:0] TMAX = 50'sh0_7FFF_FFFF_FFFF;
   localparam logic signed [49:0] TMIN = -50'sh0_8000_0000_0000;
   localparam logic signed [49:0] I32MAX = 50'sh7FFF_FFFF;
   localparam logic signed [49:0] I32MIN = -50'sh8000_0000;

   function automatic logic signed [47:0] sat48(input logic [79:0] m, input logic neg);
      logic signed [47:0] v;
      if (m >= 80'h8000_0000_0000) v = neg ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
      else v = neg ? -$signed(m[47:0]) : $signed(m[47:0]);
      return v;
   endfunction

   function automatic logic signed [49:0] clamp50(input logic signed [49:0] x,
         input logic signed [49:0] lo, input logic signed [49:0] hi);
      logic signed [49:0] v;
      if (x < lo) v = lo;
      else if (x > hi) v = hi;
      else v = x;
      return v;
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] x);
      return x[31] ? 32'(-x) : 32'(x);
   endfunction

   // configuration registers
   logic signed [31:0] gp_ff, gi_ff, gd_ff, olo_ff, ohi_ff, ilo_ff, ihi_ff;
   logic [1:0]         en_ff;
   logic               cfg_wr;
   logic [2:0]         cfg_idx;

   assign csr_pready = 1'b1;
   assign cfg_idx = csr_paddr[4:2];
   assign cfg_wr = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         gp_ff <= '0; gi_ff <= '0; gd_ff <= '0; olo_ff <= '0;
         ohi_ff <= '0; ilo_ff <= '0; ihi_ff <= '0; en_ff <= '0;
      end else if (cfg_wr) begin
         case (cfg_idx)
            R_GP:    gp_ff <= csr_pwdata;
            R_GI:    gi_ff <= csr_pwdata;
            R_GD:    gd_ff <= csr_pwdata;
            R_OLO:   olo_ff <= csr_pwdata;
            R_OHI:   ohi_ff <= csr_pwdata;
            R_ILO:   ilo_ff <= csr_pwdata;
            R_IHI:   ihi_ff <= csr_pwdata;
            R_EN:    en_ff <= csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cfg_idx)
         R_GP:    csr_prdata = gp_ff;
         R_GI:    csr_prdata = gi_ff;
         R_GD:    csr_prdata = gd_ff;
         R_OLO:   csr_prdata = olo_ff;
         R_OHI:   csr_prdata = ohi_ff;
         R_ILO:   csr_prdata = ilo_ff;
         R_IHI:   csr_prdata = ihi_ff;
         R_EN:    csr_prdata = {30'd0, en_ff};
         default: csr_prdata = '0;
      endcase
   end

   // datapath state
   logic [3:0]         st_ff, st_in;
   logic signed [47:0] acc_ff, acc_in, p_ff, p_in, it_ff, it_in, dt_ff, dt_in;
   logic signed [31:0] err_ff, err_in, last_err_ff, last_err_in;
   logic [31:0]        stamp_ff, stamp_in, last_stamp_ff, last_stamp_in, d_ff, d_in;
   logic               hist_ff, hist_in;
   logic [31:0]        res_ctl_ff, res_ctl_in;
   logic               res_st_ff, res_st_in;
   logic               rv_ff, rv_in, ru_ff, ru_in;
   logic [31:0]        rd_ff, rd_in;

   logic               mul_start, mul_done, div_start, div_done;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   mul_prod_type       prod;
   logic [DIV_N_W-1:0] div_n;
   logic [DIV_D_W-1:0] div_d;
   div_quo_type        quo;

   logic signed [31:0] req_err;
   logic [31:0]        dcur;
   logic signed [32:0] diff;
   logic [79:0]        prnd;
   logic [77:0]        nq;
   logic signed [49:0] s50, u50;

   tspid_mul u_mul (.clock(clock), .reset(reset), .start(mul_start), .a(mul_a),
                    .b(mul_b), .done(mul_done), .prod(prod));
   tspid_div u_div (.clock(clock), .reset(reset), .start(div_start), .dividend(div_n),
                    .divisor(div_d), .done(div_done), .quo(quo));

   assign req_tready = (st_ff == S_IDLE);
   assign req_err = req_tdata[31:0];

   always_comb begin
      st_in = st_ff;
      acc_in = acc_ff; p_in = p_ff; it_in = it_ff; dt_in = dt_ff;
      err_in = err_ff; last_err_in = last_err_ff;
      stamp_in = stamp_ff; last_stamp_in = last_stamp_ff; d_in = d_ff;
      hist_in = hist_ff;
      res_ctl_in = res_ctl_ff; res_st_in = res_st_ff;
      rv_in = rv_ff & ~rsp_tready; ru_in = ru_ff; rd_in = rd_ff;
      mul_start = 1'b0; mul_a = '0; mul_b = '0;
      div_start = 1'b0; div_n = '0; div_d = '0;
      dcur = stamp_ff - last_stamp_ff;
      diff = 33'(err_ff) - 33'(last_err_ff);
      prnd = prod + 80'd32768;
      nq = 78'(prod[63:0]) * 78'd15625 + {37'd0, d_ff, 9'd0};
      s50 = '0;
      u50 = '0;
      case (st_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               err_in = req_err;
               stamp_in = req_tdata[63:32];
               if (req_tuser[0]) begin
                  acc_in = '0; last_err_in = '0; last_stamp_in = '0; hist_in = 1'b0;
                  res_ctl_in = '0; res_st_in = 1'b0;
                  st_in = S_OUT;
               end else begin
                  mul_start = 1'b1;
                  mul_a = MUL_A_W'(mag32(req_err));
                  mul_b = mag32(gp_ff);
                  st_in = S_P;
               end
            end
         end
         S_P: begin
            if (mul_done) begin
               p_in = sat48({16'd0, prnd[79:16]}, gp_ff[31] != err_ff[31]);
               it_in = '0;
               dt_in = '0;
               if (!hist_ff) begin
                  st_in = S_SUM;
               end else if (stamp_ff <= last_stamp_ff) begin
                  res_ctl_in = '0; res_st_in = 1'b1;
                  st_in = S_OUT;
               end else begin
                  d_in = dcur;
                  if (gi_ff != '0) begin
                     mul_start = 1'b1;
                     mul_a = MUL_A_W'(mag32(err_ff));
                     mul_b = dcur;
                     st_in = S_IM;
                  end else begin
                     st_in = S_ITS;
                  end
               end
            end
         end
         S_IM: begin
            if (mul_done) begin
               div_start = 1'b1;
               div_n = prod[71:0] + 72'd500000;
               div_d = 32'd1000000;
               st_in = S_ID;
            end
         end
         S_ID: begin
            if (div_done) begin
               s50 = err_ff[31] ? 50'(acc_ff) - $signed({2'b0, quo[47:0]})
                               : 50'(acc_ff) + $signed({2'b0, quo[47:0]});
               s50 = clamp50(s50, TMIN, TMAX);
               if (en_ff[1]) s50 = clamp50(s50, 50'(ilo_ff), 50'(ihi_ff));
               acc_in = s50[47:0];
               st_in = S_ITS;
            end
         end
         S_ITS: begin
            mul_start = 1'b1;
            mul_a = acc_ff[47] ? 48'(-acc_ff) : 48'(acc_ff);
            mul_b = mag32(gi_ff);
            st_in = S_IT;
         end
         S_IT: begin
            if (mul_done) begin
               it_in = sat48({16'd0, prnd[79:16]}, gi_ff[31] != acc_ff[47]);
               if (gd_ff != '0) begin
                  mul_start = 1'b1;
                  mul_a = diff[32] ? 48'(-diff) : 48'(diff);
                  mul_b = mag32(gd_ff);
                  st_in = S_DM;
               end else begin
                  st_in = S_SUM;
               end
            end
         end
         S_DM: begin
            if (mul_done) begin
               // round(q * 15625 / (d * 1024)) with q = |kd| * |diff|
               div_start = 1'b1;
               div_n = {4'd0, nq[77:10]};
               div_d = d_ff;
               st_in = S_DD;
            end
         end
         S_DD: begin
            if (div_done) begin
               dt_in = sat48({8'd0, quo}, gd_ff[31] != diff[32]);
               st_in = S_SUM;
            end
         end
         S_SUM: begin
            u50 = 50'(p_ff) + 50'(it_ff) + 50'(dt_ff);
            if (en_ff[0]) u50 = clamp50(u50, 50'(olo_ff), 50'(ohi_ff));
            else u50 = clamp50(u50, I32MIN, I32MAX);
            res_ctl_in = u50[31:0];
            res_st_in = 1'b0;
            last_err_in = err_ff;
            last_stamp_in = stamp_ff;
            hist_in = 1'b1;
            st_in = S_OUT;
         end
         S_OUT: begin
            if (!rv_ff || rsp_tready) begin
               rv_in = 1'b1;
               rd_in = res_ctl_ff;
               ru_in = res_st_ff;
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         acc_ff <= '0;
         last_err_ff <= '0;
         last_stamp_ff <= '0;
         hist_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         acc_ff <= acc_in;
         last_err_ff <= last_err_in;
         last_stamp_ff <= last_stamp_in;
         hist_ff <= hist_in;
         rv_ff <= rv_in;
      end
      p_ff <= p_in; it_ff <= it_in; dt_ff <= dt_in;
      err_ff <= err_in; stamp_ff <= stamp_in; d_ff <= d_in;
      res_ctl_ff <= res_ctl_in; res_st_ff <= res_st_in;
      rd_ff <= rd_in; ru_ff <= ru_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = rd_ff;
   assign rsp_tuser = ru_ff;
endmodule
`default_nettype wire
